// File: hdl/pair_histogram_top_three_core_macros.svh
// Assertion macros for the pair histogram core.
// Used by the top level; clk and rst must be in scope at the point of use.
`ifndef PAIR_HISTOGRAM_TOP_THREE_CORE_MACROS_SVH
`define PAIR_HISTOGRAM_TOP_THREE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pair histogram: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pair histogram: next-cycle check failed");

`endif

// File: hdl/pht_pkg.sv
// Shared constants and types for the pair histogram core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pht_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int BYTE_W = 8;
  localparam int KEY_W  = 16;
  localparam int RANKS  = 3;
  localparam int RANK_W = 2;

  localparam logic [BYTE_W-1:0] DOT_BYTE     = 8'h2E;
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [RANK_W-1:0] RANK_LAST    = 2'd2;

  // Broadcast control to every cell of the chain
  typedef struct packed {
    logic             shift;  // take neighbour's entry (report scan)
    logic             upd;    // look up / count the broadcast key
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/pht_if.sv
// Valid/ready channel interfaces for text input and report output.
// Depends on pht_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pht_in_if;
  logic                       valid;
  logic                       ready;
  logic [pht_pkg::BYTE_W-1:0] ch;
  logic                       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface pht_out_if;
  logic                       valid;
  logic                       ready;
  logic [pht_pkg::RANK_W-1:0] rank;
  logic [pht_pkg::BYTE_W-1:0] first_byte;
  logic [pht_pkg::BYTE_W-1:0] second_byte;
  logic [15:0]                pair_count;
  logic                       valid_res;
  logic                       dropped;
  logic                       last;

  modport source (output valid, output rank, output first_byte, output second_byte,
                  output pair_count, output valid_res, output dropped, output last,
                  input ready);
  modport sink   (input valid, input rank, input first_byte, input second_byte,
                  input pair_count, input valid_res, input dropped, input last,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/pht_cell.sv
// One table cell: holds a pair key and its saturating count.
// Depends on pht_pkg (cell_ctl_t, KEY_W).
`timescale 1ns / 1ps
`default_nettype none

module pht_cell #(
  parameter int COUNT_WIDTH = pht_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire pht_pkg::cell_ctl_t         ctl,
  input  wire logic                       in_use,
  input  wire logic                       write_en,
  input  wire logic [pht_pkg::KEY_W-1:0]  nb_key,
  input  wire logic [COUNT_WIDTH-1:0]     nb_count,
  output logic      [pht_pkg::KEY_W-1:0]  key,
  output logic      [COUNT_WIDTH-1:0]     count,
  output logic                            hit
);

  assign hit = in_use && (key == ctl.key);

  // Payload only; occupancy comes from the fill count at the top
  always_ff @(posedge clk) begin
    priority if (ctl.shift) begin
      key   <= nb_key;
      count <= nb_count;
    end else if (ctl.upd && hit) begin
      if (count != '1) begin
        count <= count + COUNT_WIDTH'(1);
      end
    end else if (write_en) begin
      key   <= ctl.key;
      count <= COUNT_WIDTH'(1);
    end
  end

endmodule

`default_nettype wire

// File: hdl/pht_top3.sv
// Running top-three selector fed one entry per cycle during the report scan.
// Depends on pht_pkg (KEY_W, RANKS).
`timescale 1ns / 1ps
`default_nettype none

module pht_top3 #(
  parameter int COUNT_WIDTH = pht_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      clear,
  input  wire logic                      load,
  input  wire logic [pht_pkg::KEY_W-1:0] key,
  input  wire logic [COUNT_WIDTH-1:0]    count,
  output logic      [pht_pkg::KEY_W-1:0] best_key   [pht_pkg::RANKS],
  output logic      [COUNT_WIDTH-1:0]    best_count [pht_pkg::RANKS],
  output logic      [pht_pkg::RANKS-1:0] best_valid
);

  // Strict greater-than: earlier entries keep their place on ties
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best_valid <= '0;
      for (int r = 0; r < pht_pkg::RANKS; r++) begin
        best_key[r]   <= '0;
        best_count[r] <= '0;
      end
    end else if (load) begin
      priority if (count > best_count[0]) begin
        best_key[2]   <= best_key[1];
        best_count[2] <= best_count[1];
        best_valid[2] <= best_valid[1];
        best_key[1]   <= best_key[0];
        best_count[1] <= best_count[0];
        best_valid[1] <= best_valid[0];
        best_key[0]   <= key;
        best_count[0] <= count;
        best_valid[0] <= 1'b1;
      end else if (count > best_count[1]) begin
        best_key[2]   <= best_key[1];
        best_count[2] <= best_count[1];
        best_valid[2] <= best_valid[1];
        best_key[1]   <= key;
        best_count[1] <= count;
        best_valid[1] <= 1'b1;
      end else if (count > best_count[2]) begin
        best_key[2]   <= key;
        best_count[2] <= count;
        best_valid[2] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/pair_histogram_top_three_core.sv
// Pair histogram with top-three report. A byte transaction is taken in the idle state; when it
// forms a countable pair, its key is registered first and then matched in all cells.
// A report: the trigger, a scan of the N entries (one per cycle out of the cell chain),
// then three result transactions, at most one a cycle.
// Reset (rst, synchronous) empties the table by clearing the fill count; the cells
// themselves are not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "pair_histogram_top_three_core_macros.svh"

module pair_histogram_top_three_core #(
  parameter int TABLE_DEPTH = pht_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_WIDTH = pht_pkg::COUNT_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  pht_in_if.sink    text,
  pht_out_if.source report
);

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  // Controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;  // take a text byte
  localparam logic [1:0] ST_UPDATE = 2'd1;  // match / count / insert
  localparam logic [1:0] ST_SCAN   = 2'd2;  // stream entries into the selector
  localparam logic [1:0] ST_OUT    = 2'd3;  // hand out the three ranks

  logic [1:0]                  state;
  logic [pht_pkg::BYTE_W-1:0]  previous_byte;
  logic                        have_previous;
  logic [UW-1:0]               entries_used;
  logic [UW-1:0]               scan_count;
  logic                        overflow_seen;
  logic [pht_pkg::KEY_W-1:0]   pair_key;
  logic [pht_pkg::RANK_W-1:0]  rank;

  logic accept;
  logic has_newline;
  logic has_dot;
  logic table_full;
  logic any_hit;
  logic scan_load;

  pht_pkg::cell_ctl_t ctl;

  logic [pht_pkg::KEY_W-1:0] cell_key   [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]    cell_count [TABLE_DEPTH];
  logic [pht_pkg::KEY_W-1:0] nb_key     [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]    nb_count   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    hit_vec;

  logic [pht_pkg::KEY_W-1:0] best_key   [pht_pkg::RANKS];
  logic [COUNT_WIDTH-1:0]    best_count [pht_pkg::RANKS];
  logic [pht_pkg::RANKS-1:0] best_valid;

  // ---------------------------------------------------------------------------
  // Input side: a byte is taken only when the controller is idle
  // ---------------------------------------------------------------------------
  assign text.ready = (state == ST_IDLE);
  assign accept     = text.valid && text.ready;

  assign has_newline = (previous_byte == pht_pkg::NEWLINE_BYTE) ||
                       (text.ch == pht_pkg::NEWLINE_BYTE);
  assign has_dot     = (previous_byte == pht_pkg::DOT_BYTE) ||
                       (text.ch == pht_pkg::DOT_BYTE);

  assign table_full = (entries_used == UW'(TABLE_DEPTH));
  assign any_hit    = |hit_vec;
  assign scan_load  = (state == ST_SCAN) && (scan_count != entries_used);

  // Broadcast to the chain. During the scan every cell takes its upper neighbour's
  // entry, so entries leave cell 0 in order of first appearance.
  assign ctl.shift = scan_load;
  assign ctl.upd   = (state == ST_UPDATE);
  assign ctl.key   = pair_key;

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam logic [UW-1:0] IDX = UW'(g);

    logic in_use;
    logic write_en;

    // Entries below the fill count are live; a miss lands in the first free cell
    assign in_use   = (entries_used > IDX);
    assign write_en = ctl.upd && !any_hit && (entries_used == IDX);

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign nb_key[g]   = '0;
      assign nb_count[g] = '0;
    end else begin : g_link
      assign nb_key[g]   = cell_key[g+1];
      assign nb_count[g] = cell_count[g+1];
    end

    pht_cell #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .in_use   (in_use),
      .write_en (write_en),
      .nb_key   (nb_key[g]),
      .nb_count (nb_count[g]),
      .key      (cell_key[g]),
      .count    (cell_count[g]),
      .hit      (hit_vec[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Ranking unit, held clear while idle
  // ---------------------------------------------------------------------------
  pht_top3 #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_top3 (
    .clk        (clk),
    .rst        (rst),
    .clear      (state == ST_IDLE),
    .load       (scan_load),
    .key        (cell_key[0]),
    .count      (cell_count[0]),
    .best_key   (best_key),
    .best_count (best_count),
    .best_valid (best_valid)
  );

  // Pair key register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      pair_key <= {previous_byte, text.ch};
    end
  end

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      previous_byte <= '0;
      have_previous <= 1'b0;
      entries_used  <= '0;
      scan_count    <= '0;
      overflow_seen <= 1'b0;
      rank          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (text.end_of_text) begin
              state         <= ST_SCAN;
              scan_count    <= '0;
              previous_byte <= '0;
              have_previous <= 1'b0;
            end else if (!have_previous) begin
              // first byte of a text: stored only, even a newline
              previous_byte <= text.ch;
              have_previous <= 1'b1;
            end else if (has_newline) begin
              state         <= ST_SCAN;
              scan_count    <= '0;
              previous_byte <= '0;
              have_previous <= 1'b0;
            end else begin
              previous_byte <= text.ch;
              if (!has_dot) begin
                state <= ST_UPDATE;
              end
            end
          end
        end
        ST_UPDATE: begin
          // a hit is counted inside its cell; a miss is inserted or dropped
          if (!any_hit) begin
            if (table_full) begin
              overflow_seen <= 1'b1;
            end else begin
              entries_used <= entries_used + UW'(1);
            end
          end
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_count == entries_used) begin
            state <= ST_OUT;
            rank  <= '0;
          end else begin
            scan_count <= scan_count + UW'(1);
          end
        end
        ST_OUT: begin
          if (report.ready) begin
            if (rank == pht_pkg::RANK_LAST) begin
              // report done: the text starts over with an empty table
              state         <= ST_IDLE;
              entries_used  <= '0;
              overflow_seen <= 1'b0;
            end else begin
              rank <= rank + pht_pkg::RANK_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: fields come straight from the ranking registers
  // ---------------------------------------------------------------------------
  logic [pht_pkg::KEY_W-1:0] sel_key;
  logic [COUNT_WIDTH-1:0]    sel_count;
  logic                      sel_valid;
  logic [31:0]               count_ext;

  always_comb begin
    unique case (rank)
      2'd0: begin
        sel_key   = best_key[0];
        sel_count = best_count[0];
        sel_valid = best_valid[0];
      end
      2'd1: begin
        sel_key   = best_key[1];
        sel_count = best_count[1];
        sel_valid = best_valid[1];
      end
      2'd2: begin
        sel_key   = best_key[2];
        sel_count = best_count[2];
        sel_valid = best_valid[2];
      end
      default: begin
        sel_key   = '0;
        sel_count = '0;
        sel_valid = 1'b0;
      end
    endcase
  end

  assign count_ext = 32'(sel_count);

  assign report.valid       = (state == ST_OUT);
  assign report.rank        = rank;
  assign report.first_byte  = sel_valid ? sel_key[15:8] : '0;
  assign report.second_byte = sel_valid ? sel_key[7:0] : '0;
  assign report.pair_count  = sel_valid ? count_ext[15:0] : '0;
  assign report.valid_res   = sel_valid;
  assign report.dropped     = overflow_seen;
  assign report.last        = (rank == pht_pkg::RANK_LAST);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a key lives in at most one cell
  `PHT_ASSERT_IMPL(a_single_hit, state == ST_UPDATE, $onehot0(hit_vec))
  // dropping only ever happens with a full table
  `PHT_ASSERT_IMPL(a_drop_when_full, overflow_seen, entries_used == UW'(TABLE_DEPTH))
  // scan never runs past the fill count
  `PHT_ASSERT_IMPL(a_scan_bound, state == ST_SCAN, scan_count <= entries_used)
  // the final rank empties the table
  `PHT_ASSERT_NEXT(a_clear_after_report, report.valid && report.ready && report.last, state == ST_IDLE && entries_used == '0)

endmodule

`default_nettype wire

// File: dv/pair_histogram_top_three_core_checker.sv
// Scoreboard for the pair histogram core: watches both channels, predicts each report.
// Depends on pht_pkg (widths, special bytes) and pht_if (channel interfaces).
`timescale 1ns / 1ps

module pair_histogram_top_three_core_checker (
  input  wire logic clk,
  input  wire logic rst,
  pht_in_if         text,
  pht_out_if        report,
  output int        pending,
  output int        failures,
  output int        results_checked
);
  import pht_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_WIDTH_DEF) - 1;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [15:0]       pair_count;
    logic              valid_res;
    logic              dropped;
    logic              last;
  } ranked_pair_t;

  ranked_pair_t ranking_q[$];

  // Predictor copy of the text state
  logic [BYTE_W-1:0] prev_byte;
  logic              have_prev;
  logic [KEY_W-1:0]  keys [DEPTH];
  longint unsigned   counts [DEPTH];
  int                used;
  logic              overflow;

  int fail_cnt = 0;
  int seen_cnt = 0;

  assign failures        = fail_cnt;
  assign results_checked = seen_cnt;

  function automatic void clear_text();
    prev_byte = '0;
    have_prev = 1'b0;
    used      = 0;
    overflow  = 1'b0;
  endfunction

  function automatic void tally_pair(logic [KEY_W-1:0] key);
    for (int i = 0; i < used; i++) begin
      if (keys[i] == key) begin
        if (counts[i] < COUNT_CEIL) counts[i]++;
        return;
      end
    end
    if (used < DEPTH) begin
      keys[used]   = key;
      counts[used] = 1;
      used++;
    end else begin
      overflow = 1'b1;
    end
  endfunction

  // Top three by strict greater-than (earlier entry keeps a tie), then the table is emptied
  function automatic void rank_table();
    longint unsigned best_cnt [RANKS];
    int              best_idx [RANKS];
    bit              best_ok  [RANKS];
    int              slot;
    ranked_pair_t    r;
    for (int k = 0; k < RANKS; k++) begin
      best_cnt[k] = 0;
      best_idx[k] = 0;
      best_ok[k]  = 1'b0;
    end
    for (int i = 0; i < used; i++) begin
      slot = RANKS;
      for (int k = RANKS - 1; k >= 0; k--) begin
        if (counts[i] > best_cnt[k]) slot = k;
      end
      if (slot < RANKS) begin
        for (int k = RANKS - 1; k > slot; k--) begin
          best_cnt[k] = best_cnt[k-1];
          best_idx[k] = best_idx[k-1];
          best_ok[k]  = best_ok[k-1];
        end
        best_cnt[slot] = counts[i];
        best_idx[slot] = i;
        best_ok[slot]  = 1'b1;
      end
    end
    for (int k = 0; k < RANKS; k++) begin
      r.rank        = RANK_W'(k);
      r.first_byte  = best_ok[k] ? keys[best_idx[k]][KEY_W-1:BYTE_W] : '0;
      r.second_byte = best_ok[k] ? keys[best_idx[k]][BYTE_W-1:0] : '0;
      r.pair_count  = best_ok[k] ? best_cnt[k][15:0] : '0;
      r.valid_res   = best_ok[k];
      r.dropped     = overflow;
      r.last        = (r.rank == RANK_LAST);
      ranking_q.push_back(r);
    end
    clear_text();
  endfunction

  function automatic void predict_text(logic [BYTE_W-1:0] c, logic eot);
    logic [BYTE_W-1:0] a;
    if (eot) begin
      rank_table();
      return;
    end
    if (!have_prev) begin
      prev_byte = c;
      have_prev = 1'b1;
      return;
    end
    a         = prev_byte;
    prev_byte = c;
    if (a == NEWLINE_BYTE || c == NEWLINE_BYTE) rank_table();
    else if (a != DOT_BYTE && c != DOT_BYTE) tally_pair({a, c});
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Outputs first, then inputs: a result can never belong to a transaction of the same edge
  always @(posedge clk) begin : watch
    ranked_pair_t want;
    if (rst) begin
      clear_text();
      ranking_q.delete();
    end else begin
      if (report.valid && report.ready) begin
        seen_cnt++;
        if (ranking_q.size() == 0) begin
          $error("report transaction with nothing expected (rank %0d)", report.rank);
          fail_cnt++;
        end else begin
          want = ranking_q.pop_front();
          compare_field("rank",        want.rank,        report.rank);
          compare_field("first_byte",  want.first_byte,  report.first_byte);
          compare_field("second_byte", want.second_byte, report.second_byte);
          compare_field("pair_count",  want.pair_count,  report.pair_count);
          compare_field("valid_res",   want.valid_res,   report.valid_res);
          compare_field("dropped",     want.dropped,     report.dropped);
          compare_field("last",        want.last,        report.last);
        end
      end
      if (text.valid && text.ready) predict_text(text.ch, text.end_of_text);
    end
    pending <= ranking_q.size();
  end

endmodule

// File: dv/pair_histogram_top_three_core_tb.sv
// Top of the pair histogram testbench: clock, reset, text stimulus and report back-pressure.
// Depends on pht_pkg, pht_if, the core RTL and pair_histogram_top_three_core_checker.
`timescale 1ns / 1ps

module pair_histogram_top_three_core_tb;
  import pht_pkg::*;

  // The longest legal gap between transactions, a full-table report scan plus random
  // stalls, stays far below the limit; the end-of-run quiet window is shorter still.
  localparam int IDLE_LIMIT     = 5000;
  localparam int QUIET_CYCLES   = 2 * TABLE_DEPTH_DEF + 20;
  localparam int PHASE_ITEMS    = 75;
  localparam int FILL_BYTES     = 150;
  localparam int REPEAT_BYTES   = 8;

  logic clk;
  logic rst;

  pht_in_if  text ();
  pht_out_if report ();

  int send_idle_pct = 0;   // chance of a sender gap cycle before each transaction
  int stall_pct     = 0;   // chance the report side holds ready low in a cycle
  int items_sent    = 0;
  int idle_cycles   = 0;

  int pending;
  int failures;
  int results_checked;

  pair_histogram_top_three_core DUT (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .report (report)
  );

  pair_histogram_top_three_core_checker report_scoreboard (
    .clk             (clk),
    .rst             (rst),
    .text            (text),
    .report          (report),
    .pending         (pending),
    .failures        (failures),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Report side back-pressure: a fresh coin each cycle at the current stall rate
  initial begin
    report.ready = 1'b0;
    forever begin
      @(posedge clk);
      report.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a long stretch with no transaction on either channel means a hang
  always @(posedge clk) begin
    if (rst || (text.valid && text.ready) || (report.valid && report.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One text transaction; optional gap cycles first, then hold valid until ready.
  // Each path assigns valid once per time step, so no drop-and-raise in one step.
  task automatic put_item(input logic [BYTE_W-1:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      text.valid <= 1'b0;
      @(posedge clk);
    end
    text.valid       <= 1'b1;
    text.ch          <= c;
    text.end_of_text <= eot;
    do @(posedge clk); while (!text.ready);
    items_sent++;
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] c);
    put_item(c, 1'b0);
  endtask

  // End of text; ch carries junk, which the block must ignore
  task automatic put_eot();
    put_item(BYTE_W'($urandom_range(255)), 1'b1);
  endtask

  // Pause the sender until every predicted report transaction has come out.
  // pending is registered, so the task always waits for a clock before it looks.
  task automatic wait_reports_drained();
    text.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Any byte that neither ends the text nor blocks the pair
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(255));
    while (c == DOT_BYTE || c == NEWLINE_BYTE);
    return c;
  endfunction

  // Mostly a tiny alphabet so pairs repeat and ties happen; some dots, newlines, noise
  function automatic logic [BYTE_W-1:0] text_byte();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55)      return 8'h61 + BYTE_W'($urandom_range(3));
    else if (sel < 65) return DOT_BYTE;
    else if (sel < 70) return NEWLINE_BYTE;
    else               return BYTE_W'($urandom_range(255));
  endfunction

  // A short text, usually closed by end-of-text or newline, sometimes left running
  task automatic random_text();
    int len;
    int close_sel;
    len = $urandom_range(12, 1);
    for (int i = 0; i < len; i++) put_byte(text_byte());
    close_sel = $urandom_range(99);
    if (close_sel < 45)      put_eot();
    else if (close_sel < 85) put_byte(NEWLINE_BYTE);
  endtask

  // More distinct pairs than the table holds, then replay the opening so that
  // pairs already entered keep counting after the table is full
  task automatic overfill_table();
    logic [BYTE_W-1:0] opening [REPEAT_BYTES];
    logic [BYTE_W-1:0] c;
    for (int i = 0; i < FILL_BYTES; i++) begin
      c = plain_byte();
      if (i < REPEAT_BYTES) opening[i] = c;
      put_byte(c);
    end
    for (int i = 0; i < REPEAT_BYTES; i++) put_byte(opening[i]);
    if ($urandom_range(1)) put_eot();
    else                   put_byte(NEWLINE_BYTE);
  endtask

  initial begin
    int send_mix  [4];
    int stall_mix [4];
    int phase_start;
    send_mix  = '{0, 57, 0, 34};
    stall_mix = '{0, 0, 57, 34};

    rst              = 1'b1;
    text.valid       = 1'b0;
    text.ch          = '0;
    text.end_of_text = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // --- directed part, no idling ---
    // report straight out of reset: all three ranks empty
    put_eot();
    // a newline as the first byte is only stored; the next pair holds it and
    // ends the text with an empty table
    put_byte(NEWLINE_BYTE);
    put_byte(8'h61);
    // byte extremes, pairs with a dot skipped, a tie won by the earlier entry,
    // end-of-text carrying a non-zero byte
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(DOT_BYTE);
    put_byte(8'h78);
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_item(8'hFF, 1'b1);
    // newline mid-text: two entries, third rank empty
    put_byte(8'h61);
    put_byte(8'h62);
    put_byte(8'h61);
    put_byte(8'h62);
    put_byte(NEWLINE_BYTE);
    // only dot pairs, then a text of a single byte
    put_byte(DOT_BYTE);
    put_byte(DOT_BYTE);
    put_byte(8'h7A);
    put_eot();
    put_byte(8'h41);
    put_eot();
    wait_reports_drained();

    // --- random part: four idling mixes, drained between them ---
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_mix[p];
      stall_pct     = stall_mix[p];
      phase_start   = items_sent;
      if (p == 3) overfill_table();
      while (items_sent - phase_start < PHASE_ITEMS) random_text();
      put_eot();
      wait_reports_drained();
    end

    // quiet window to catch any stray late report transaction
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("Run covered %0d text transactions: directed edge cases, a full table",
             items_sent);
    $display("with dropped pairs, four idling mixes; %0d results checked.",
             results_checked);
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
